// ===== src/cutt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cutt_pkg: shared types, codes and helpers of the card user table
// Item layouts, account and material codes, register indexes, the token that
// walks the cell chain, and the UID compare and tally increment helpers.
// ----------------------------------------------------------------------------
package cutt_pkg;

   localparam int UID_W      = 56;
   localparam int LEN_W      = 3;
   localparam int MAT_W      = 3;
   localparam int KIND_W     = 3;
   localparam int SLOT_W     = 5;
   localparam int TALLY_W    = 32;
   localparam int CSR_IDX_W  = 2;
   // table index and fill count cover the largest table size (256 users)
   localparam int SLOT_IDX_W = 8;
   localparam int CNT_W      = 9;

   // account kinds
   localparam logic [KIND_W-1:0] KIND_USER   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GUEST  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MASTER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TOTAL  = 3'd4;

   // material codes
   localparam logic [MAT_W-1:0] MAT_NONE    = 3'd0;
   localparam logic [MAT_W-1:0] MAT_GLASS   = 3'd1;
   localparam logic [MAT_W-1:0] MAT_METAL   = 3'd2;
   localparam logic [MAT_W-1:0] MAT_PLASTIC = 3'd3;
   localparam logic [MAT_W-1:0] MAT_CUP     = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_UID      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_UID_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_UID     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_UID_LEN = 2'd3;

   // register reset values
   localparam logic [UID_W-1:0] CLEAR_UID_RST      = 56'h0000001E2EA932;
   localparam logic [LEN_W-1:0] CLEAR_UID_LEN_RST  = 3'd4;
   localparam logic [UID_W-1:0] MASTER_UID_RST     = 56'h805AE5C2547904;
   localparam logic [LEN_W-1:0] MASTER_UID_LEN_RST = 3'd7;

   typedef struct packed {
      logic             has_card;
      logic [UID_W-1:0] card_uid;
      logic [LEN_W-1:0] card_uid_len;
      logic [MAT_W-1:0] material;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] account_kind;
      logic [SLOT_W-1:0] user_slot;
      logic              newly_enrolled;
      logic              counted;
      logic [7:0]        plastic_tally;
      logic [7:0]        metal_tally;
      logic [7:0]        glass_tally;
      logic [7:0]        cup_tally;
      logic              last_result;
   } rsp_type;

   // lookup token handed from cell to cell
   typedef struct packed {
      logic                  vld;
      logic [UID_W-1:0]      uid;
      logic [LEN_W-1:0]      len;
      logic [MAT_W-1:0]      mat;
      logic                  found;
      logic                  enrolled;
      logic [SLOT_IDX_W-1:0] slot;
      logic [TALLY_W-1:0]    tally;
   } token_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   // keep the bytes below the UID length
   function automatic logic [UID_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [UID_W-1:0] m;
      m = '0;
      for (int b = 0; b < UID_W / 8; b++) begin
         if (LEN_W'(b) < len) begin
            m[8*b +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   function automatic logic uid_match(input logic [UID_W-1:0] a,
                                      input logic [LEN_W-1:0] alen,
                                      input logic [UID_W-1:0] b,
                                      input logic [LEN_W-1:0] blen);
      return (alen == blen) && (((a ^ b) & len_mask(alen)) == '0);
   endfunction

   function automatic logic mat_counts(input logic [MAT_W-1:0] mat);
      return (mat == MAT_GLASS) || (mat == MAT_METAL) ||
             (mat == MAT_PLASTIC) || (mat == MAT_CUP);
   endfunction

   // add one to the byte counter of the material, wrapping at 8 bits
   function automatic logic [TALLY_W-1:0] tally_bump(input logic [TALLY_W-1:0] t,
                                                     input logic [MAT_W-1:0] mat);
      logic [TALLY_W-1:0] r;
      r = t;
      case (mat)
         MAT_PLASTIC: r[7:0]   = t[7:0]   + 8'd1;
         MAT_METAL:   r[15:8]  = t[15:8]  + 8'd1;
         MAT_GLASS:   r[23:16] = t[23:16] + 8'd1;
         MAT_CUP:     r[31:24] = t[31:24] + 8'd1;
         default:     r = t;
      endcase
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic [KIND_W-1:0] kind,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic enrolled,
                                        input logic counted,
                                        input logic [TALLY_W-1:0] tally,
                                        input logic last);
      rsp_type r;
      r.account_kind   = kind;
      r.user_slot      = slot;
      r.newly_enrolled = enrolled;
      r.counted        = counted;
      r.plastic_tally  = tally[7:0];
      r.metal_tally    = tally[15:8];
      r.glass_tally    = tally[23:16];
      r.cup_tally      = tally[31:24];
      r.last_result    = last;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/cutt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cutt_cell: one user table entry
// Holds one UID, its length and its tally word. Checks the passing token,
// bumps its tally on a hit, takes the UID when it is the next free entry,
// and registers the token before handing it on.
// ----------------------------------------------------------------------------
module cutt_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [cutt_pkg::CNT_W-1:0] count_i,
   input  wire cutt_pkg::token_type     tok_i,
   output cutt_pkg::token_type          tok_o
);
   import cutt_pkg::*;

   localparam logic [CNT_W-1:0]      IDX_CNT  = CNT_W'(INDEX);
   localparam logic [SLOT_IDX_W-1:0] IDX_SLOT = SLOT_IDX_W'(INDEX);

   logic [UID_W-1:0]   uid_ff, uid_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   token_type          tok_ff, tok_in;
   logic               hit, take;

   // match against the entry, or enroll into it when it is the first free one
   always_comb begin
      uid_in   = uid_ff;
      len_in   = len_ff;
      tally_in = tally_ff;
      tok_in   = tok_i;
      hit  = tok_i.vld && !tok_i.found && (IDX_CNT < count_i) &&
             uid_match(tok_i.uid, tok_i.len, uid_ff, len_ff);
      take = tok_i.vld && !tok_i.found && (IDX_CNT == count_i);
      if (hit) begin
         tally_in     = tally_bump(tally_ff, tok_i.mat);
         tok_in.found = 1'b1;
         tok_in.slot  = IDX_SLOT;
         tok_in.tally = tally_in;
      end else if (take) begin
         uid_in          = tok_i.uid & len_mask(tok_i.len);
         len_in          = tok_i.len;
         tally_in        = tally_bump('0, tok_i.mat);
         tok_in.found    = 1'b1;
         tok_in.enrolled = 1'b1;
         tok_in.slot     = IDX_SLOT;
         tok_in.tally    = tally_in;
      end
   end

   // hold the entry
   always_ff @(posedge clock) begin
      uid_ff   <= uid_in;
      len_ff   <= len_in;
      tally_ff <= tally_in;
   end

   // advance the token
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

// ===== src/card_user_table_with_tallies.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// card_user_table_with_tallies: card user table with recycling tallies
// Checks each deposit item against the clear and master service codes, looks
// the card up in a chain of table cells, enrolls new cards while there is
// room and counts the material on the user or guest account and the total.
// ----------------------------------------------------------------------------
//   channel   ports                          handshake
//   input     start, busy, req_data          taken when start and !busy
//   result    rsp_valid, rsp_data            one cycle per result, no stall
//   config    csr_wr_en, csr_index, csr_wdata written when csr_wr_en
//
// A card lookup walks the token down the cell chain one cell per cycle and
// then emits its results: two when the material counts, else one. Service
// cards and items without a card go from the check straight to the results.
// Start is taken again in the cycle after the last result.
// Reset clears the fill count and the guest and total tallies; table entries
// are only read below the fill count and need no clearing.
// ----------------------------------------------------------------------------
module card_user_table_with_tallies #(
   parameter int MAX_USERS = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire cutt_pkg::req_type            req_data,
   output logic                              rsp_valid,
   output cutt_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_wr_en,
   input  wire logic [cutt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cutt_pkg::UID_W-1:0]   csr_wdata
);
   import cutt_pkg::*;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_USERS);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   token_type          launch_ff, launch_in;
   token_type          chain [0:MAX_USERS];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TALLY_W-1:0] guest_ff, guest_in;
   logic [TALLY_W-1:0] total_ff, total_in;
   rsp_type            rsp0_ff, rsp0_in, rsp1_ff, rsp1_in;
   logic               two_ff, two_in;
   logic [UID_W-1:0]   clear_uid_ff, master_uid_ff;
   logic [LEN_W-1:0]   clear_len_ff, master_len_ff;
   logic               accept, clear_hit, master_hit, counts;
   logic [TALLY_W-1:0] guest_bumped, total_bumped;
   token_type          tok_end;

   assign accept   = start && (state_ff == ST_IDLE);
   assign tok_end  = chain[MAX_USERS];
   assign counts   = mat_counts(req_ff.material);
   assign clear_hit  = req_ff.has_card &&
      uid_match(req_ff.card_uid, req_ff.card_uid_len, clear_uid_ff, clear_len_ff);
   assign master_hit = req_ff.has_card &&
      uid_match(req_ff.card_uid, req_ff.card_uid_len, master_uid_ff, master_len_ff);
   assign guest_bumped = tally_bump(guest_ff, req_ff.material);
   assign total_bumped = tally_bump(total_ff, req_ff.material);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_uid_ff  <= CLEAR_UID_RST;
         clear_len_ff  <= CLEAR_UID_LEN_RST;
         master_uid_ff <= MASTER_UID_RST;
         master_len_ff <= MASTER_UID_LEN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CLEAR_UID:      clear_uid_ff  <= csr_wdata;
            CSR_CLEAR_UID_LEN:  clear_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_MASTER_UID:     master_uid_ff <= csr_wdata;
            CSR_MASTER_UID_LEN: master_len_ff <= csr_wdata[LEN_W-1:0];
            default:            clear_uid_ff  <= clear_uid_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CHECK;
         ST_CHECK: begin
            if (clear_hit || master_hit || !req_ff.has_card) begin
               state_in = ST_EMIT0;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN:  if (tok_end.vld) state_in = ST_EMIT0;
         ST_EMIT0: state_in = two_ff ? ST_EMIT1 : ST_IDLE;
         ST_EMIT1: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      rsp_data  = rsp0_ff;
      unique case (state_ff)
         ST_EMIT0: rsp_valid = 1'b1;
         ST_EMIT1: begin
            rsp_valid = 1'b1;
            rsp_data  = rsp1_ff;
         end
         default:  rsp_valid = 1'b0;
      endcase
   end

   // decode the item, launch the lookup and build the results
   always_comb begin
      req_in    = req_ff;
      launch_in = '0;
      count_in  = count_ff;
      guest_in  = guest_ff;
      total_in  = total_ff;
      rsp0_in   = rsp0_ff;
      rsp1_in   = rsp1_ff;
      two_in    = two_ff;
      if (accept) begin
         req_in = req_data;
      end
      if (state_ff == ST_CHECK) begin
         if (clear_hit) begin
            count_in = '0;
            guest_in = '0;
            total_in = '0;
            rsp0_in  = make_rsp(KIND_CLEAR, '0, 1'b0, 1'b0, '0, 1'b1);
            two_in   = 1'b0;
         end else if (master_hit) begin
            rsp0_in = make_rsp(KIND_MASTER, '0, 1'b0, 1'b0, guest_ff, 1'b0);
            rsp1_in = make_rsp(KIND_TOTAL, '0, 1'b0, 1'b0, total_ff, 1'b1);
            two_in  = 1'b1;
         end else if (!req_ff.has_card) begin
            guest_in = guest_bumped;
            total_in = total_bumped;
            rsp0_in  = make_rsp(KIND_GUEST, '0, 1'b0, counts, guest_bumped, !counts);
            rsp1_in  = make_rsp(KIND_TOTAL, '0, 1'b0, 1'b1, total_bumped, 1'b1);
            two_in   = counts;
         end else begin
            launch_in.vld   = 1'b1;
            launch_in.uid   = req_ff.card_uid;
            launch_in.len   = req_ff.card_uid_len;
            launch_in.mat   = req_ff.material;
            launch_in.tally = '0;
         end
      end
      if (state_ff == ST_SCAN && tok_end.vld) begin
         total_in = total_bumped;
         rsp1_in  = make_rsp(KIND_TOTAL, '0, 1'b0, 1'b1, total_bumped, 1'b1);
         two_in   = counts;
         if (tok_end.found) begin
            if (tok_end.enrolled && count_ff < FULL_CNT) begin
               count_in = count_ff + CNT_W'(1);
            end
            rsp0_in = make_rsp(KIND_USER, tok_end.slot[SLOT_W-1:0], tok_end.enrolled,
                               counts, tok_end.tally, !counts);
         end else begin
            guest_in = guest_bumped;
            rsp0_in  = make_rsp(KIND_GUEST, '0, 1'b0, counts, guest_bumped, !counts);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= '0;
         count_ff  <= '0;
         guest_ff  <= '0;
         total_ff  <= '0;
         two_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         count_ff  <= count_in;
         guest_ff  <= guest_in;
         total_ff  <= total_in;
         two_ff    <= two_in;
      end
   end

   // hold the item and the results
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp0_ff <= rsp0_in;
      rsp1_ff <= rsp1_in;
   end

   // table cell chain
   assign chain[0] = launch_ff;

   for (genvar i = 0; i < MAX_USERS; i++) begin : g_cell
      cutt_cell #(
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count_i (count_ff),
         .tok_i   (chain[i]),
         .tok_o   (chain[i+1])
      );
   end

endmodule
`default_nettype wire

// ===== tb/card_user_table_with_tallies_tb.sv =====
// ----------------------------------------------------------------------------
// card_user_table_with_tallies_tb: self-checking bench for the card user table
// Drives deposit items through the start/busy port and predicts every report
// in a ledger class that keeps its own table, tallies and service codes. The
// bench compares each strobed report field by field, in order, and walks
// through several code settings and sender pacing modes.
// ----------------------------------------------------------------------------
module card_user_table_with_tallies_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cutt_pkg::*;

   localparam int TABLE_DEPTH   = 20;
   localparam int POOL_SIZE     = 30;
   localparam int PHASES        = 5;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 10;
   localparam int WRAP_PAIRS    = 260;
   localparam int CYCLE_LIMIT   = 400000;

   // material codes with no meaning; the block must treat them as none
   localparam logic [MAT_W-1:0] MAT_RSVD5 = 3'd5;
   localparam logic [MAT_W-1:0] MAT_RSVD6 = 3'd6;
   localparam logic [MAT_W-1:0] MAT_RSVD7 = 3'd7;

   // -------------------------------------------------------------------------
   // Ledger: predicts the reports of each deposit and checks what comes out
   // -------------------------------------------------------------------------
   class tally_ledger;
      logic [UID_W-1:0]   clear_id;
      logic [LEN_W-1:0]   clear_len;
      logic [UID_W-1:0]   master_id;
      logic [LEN_W-1:0]   master_len;
      logic [UID_W-1:0]   uid_tab   [TABLE_DEPTH];
      logic [LEN_W-1:0]   len_tab   [TABLE_DEPTH];
      logic [TALLY_W-1:0] tally_tab [TABLE_DEPTH];
      logic [TALLY_W-1:0] guest_word;
      logic [TALLY_W-1:0] total_word;
      int unsigned        enrolled;
      rsp_type            pending_reports[$];
      int unsigned        errors, deposits, reports, enrolls, clears, masters, full_hits;

      function new();
         clear_id    = CLEAR_UID_RST;
         clear_len   = CLEAR_UID_LEN_RST;
         master_id   = MASTER_UID_RST;
         master_len  = MASTER_UID_LEN_RST;
         guest_word  = '0;
         total_word  = '0;
         enrolled    = 0;
         errors      = 0;
         deposits    = 0;
         reports     = 0;
         enrolls     = 0;
         clears      = 0;
         masters     = 0;
         full_hits   = 0;
      endfunction

      // keep the UID bytes below the given length
      function logic [UID_W-1:0] byte_mask(logic [LEN_W-1:0] len);
         logic [63:0] m;
         if (len >= 3'd7) return {UID_W{1'b1}};
         m = (64'd1 << (8 * len)) - 64'd1;
         return m[UID_W-1:0];
      endfunction

      function bit same_card(logic [UID_W-1:0] a, logic [LEN_W-1:0] alen,
                             logic [UID_W-1:0] b, logic [LEN_W-1:0] blen);
         return (alen == blen) && (((a ^ b) & byte_mask(alen)) == '0);
      endfunction

      // advance the 8-bit counter of the material, wrapping
      function logic [TALLY_W-1:0] count_one(logic [TALLY_W-1:0] w, logic [MAT_W-1:0] mat);
         logic [TALLY_W-1:0] r;
         r = w;
         case (mat)
            MAT_PLASTIC: r[7:0]   = w[7:0]   + 8'd1;
            MAT_METAL:   r[15:8]  = w[15:8]  + 8'd1;
            MAT_GLASS:   r[23:16] = w[23:16] + 8'd1;
            MAT_CUP:     r[31:24] = w[31:24] + 8'd1;
            default:     r = w;
         endcase
         return r;
      endfunction

      function void queue_report(logic [KIND_W-1:0] kind, int unsigned slot, bit fresh,
                                 bit counts, logic [TALLY_W-1:0] word, bit last);
         rsp_type r;
         r.account_kind   = kind;
         r.user_slot      = SLOT_W'(slot);
         r.newly_enrolled = fresh;
         r.counted        = counts;
         r.plastic_tally  = word[7:0];
         r.metal_tally    = word[15:8];
         r.glass_tally    = word[23:16];
         r.cup_tally      = word[31:24];
         r.last_result    = last;
         pending_reports.push_back(r);
      endfunction

      function void set_code(logic [CSR_IDX_W-1:0] idx, logic [UID_W-1:0] data);
         case (idx)
            CSR_CLEAR_UID:      clear_id    = data;
            CSR_CLEAR_UID_LEN:  clear_len   = data[LEN_W-1:0];
            CSR_MASTER_UID:     master_id   = data;
            CSR_MASTER_UID_LEN: master_len  = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // work out the reports of one accepted deposit item
      function void log_deposit(req_type d);
         bit          is_user;
         bit          fresh;
         bit          counts;
         int unsigned slot;
         is_user = 0;
         fresh   = 0;
         slot    = 0;
         deposits++;
         if (d.has_card && same_card(d.card_uid, d.card_uid_len, clear_id, clear_len)) begin
            enrolled   = 0;
            guest_word = '0;
            total_word = '0;
            clears++;
            queue_report(KIND_CLEAR, 0, 0, 0, '0, 1);
            return;
         end
         if (d.has_card && same_card(d.card_uid, d.card_uid_len, master_id, master_len)) begin
            masters++;
            queue_report(KIND_MASTER, 0, 0, 0, guest_word, 0);
            queue_report(KIND_TOTAL, 0, 0, 0, total_word, 1);
            return;
         end
         // look the card up, enroll it while there is room
         if (d.has_card) begin
            for (int i = 0; i < int'(enrolled); i++) begin
               if (same_card(d.card_uid, d.card_uid_len, uid_tab[i], len_tab[i])) begin
                  is_user = 1;
                  slot    = i;
                  break;
               end
            end
            if (!is_user) begin
               if (enrolled < TABLE_DEPTH) begin
                  slot            = enrolled;
                  uid_tab[slot]   = d.card_uid & byte_mask(d.card_uid_len);
                  len_tab[slot]   = d.card_uid_len;
                  tally_tab[slot] = '0;
                  enrolled++;
                  enrolls++;
                  is_user = 1;
                  fresh   = 1;
               end else begin
                  full_hits++;
               end
            end
         end
         case (d.material)
            MAT_GLASS, MAT_METAL, MAT_PLASTIC, MAT_CUP: counts = 1;
            default: counts = 0;
         endcase
         if (counts) begin
            if (is_user) tally_tab[slot] = count_one(tally_tab[slot], d.material);
            else guest_word = count_one(guest_word, d.material);
            total_word = count_one(total_word, d.material);
         end
         queue_report(is_user ? KIND_USER : KIND_GUEST, is_user ? slot : 0, fresh, counts,
                      is_user ? tally_tab[slot] : guest_word, !counts);
         if (counts) queue_report(KIND_TOTAL, 0, 0, 1, total_word, 1);
      endfunction

      function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 0;
         end
         return 1;
      endfunction

      // compare one strobed report with the oldest prediction
      function void check_report(rsp_type got);
         rsp_type want;
         bit      bad;
         reports++;
         if (pending_reports.size() == 0) begin
            $error("report with nothing pending: kind %0d", got.account_kind);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         bad  = 0;
         bad |= !field_ok("account_kind", 8'(want.account_kind), 8'(got.account_kind));
         bad |= !field_ok("user_slot", 8'(want.user_slot), 8'(got.user_slot));
         bad |= !field_ok("newly_enrolled", 8'(want.newly_enrolled), 8'(got.newly_enrolled));
         bad |= !field_ok("counted", 8'(want.counted), 8'(got.counted));
         bad |= !field_ok("plastic_tally", want.plastic_tally, got.plastic_tally);
         bad |= !field_ok("metal_tally", want.metal_tally, got.metal_tally);
         bad |= !field_ok("glass_tally", want.glass_tally, got.glass_tally);
         bad |= !field_ok("cup_tally", want.cup_tally, got.cup_tally);
         bad |= !field_ok("last_result", 8'(want.last_result), 8'(got.last_result));
         if (bad) errors++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block and clock
   // -------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CLEAR_UID;
   logic [UID_W-1:0]     csr_wdata = '0;

   tally_ledger          ledger;
   int unsigned          cycle_count = 0;
   int unsigned          sender_idle = 0;
   int unsigned          idle_mix [PHASES] = '{0, 81, 28, 81, 0};
   logic [UID_W-1:0]     pool_uid [POOL_SIZE];
   logic [LEN_W-1:0]     pool_len [POOL_SIZE];

   card_user_table_with_tallies #(.MAX_USERS(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // sample writes, accepted items and reports at each rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) ledger.set_code(csr_index, csr_wdata);
         if (start && !busy) ledger.log_deposit(req_data);
         if (rsp_valid) ledger.check_report(rsp_data);
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout with %0d reports pending", ledger.pending_reports.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function logic [UID_W-1:0] rand_uid();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[UID_W-1:0];
   endfunction

   function req_type deposit(bit has, logic [UID_W-1:0] uid, logic [LEN_W-1:0] len,
                             logic [MAT_W-1:0] mat);
      req_type d;
      d.has_card     = has;
      d.card_uid     = uid;
      d.card_uid_len = len;
      d.material     = mat;
      return d;
   endfunction

   // mostly known cards with noise above their length, some fresh and service cards
   function req_type random_deposit();
      req_type          d;
      int unsigned      pick;
      int unsigned      k;
      logic [UID_W-1:0] noise;
      logic [UID_W-1:0] m;
      pick  = $urandom_range(99);
      noise = rand_uid();
      d.has_card     = 1'b1;
      d.card_uid     = noise;
      d.card_uid_len = LEN_W'($urandom_range(7));
      d.material     = ($urandom_range(99) < 70) ? MAT_W'($urandom_range(4, 1))
                                                 : MAT_W'($urandom_range(7));
      if (pick < 8) begin
         d.has_card = 1'b0;
      end else if (pick < 10) begin
         m              = ledger.byte_mask(ledger.clear_len);
         d.card_uid     = (noise & ~m) | (ledger.clear_id & m);
         d.card_uid_len = ledger.clear_len;
      end else if (pick < 13) begin
         m              = ledger.byte_mask(ledger.master_len);
         d.card_uid     = (noise & ~m) | (ledger.master_id & m);
         d.card_uid_len = ledger.master_len;
      end else if (pick >= 28) begin
         k              = $urandom_range(POOL_SIZE - 1);
         m              = ledger.byte_mask(pool_len[k]);
         d.card_uid     = (noise & ~m) | (pool_uid[k] & m);
         d.card_uid_len = pool_len[k];
      end
      return d;
   endfunction

   // hold start low for a random gap, then present the item until taken
   task send_deposit(input req_type item);
      if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   // drop start, wait for every report, then let the block go idle
   task drain_block();
      start <= 1'b0;
      while (ledger.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [UID_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task program_codes(input logic [UID_W-1:0] clear_uid, input logic [LEN_W-1:0] clear_len,
                      input logic [UID_W-1:0] master_uid, input logic [LEN_W-1:0] master_len);
      write_reg(CSR_CLEAR_UID, clear_uid);
      write_reg(CSR_CLEAR_UID_LEN, UID_W'(clear_len));
      write_reg(CSR_MASTER_UID, master_uid);
      write_reg(CSR_MASTER_UID_LEN, UID_W'(master_len));
      csr_wr_en <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [UID_W-1:0] code;
      logic [LEN_W-1:0] code_len;
      ledger = new();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_uid[i] = rand_uid();
         pool_len[i] = LEN_W'($urandom_range(7, 1));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle = idle_mix[phase];
         case (phase)
            1: program_codes('0, 3'd1, {UID_W{1'b1}}, 3'd7);
            2: program_codes({UID_W{1'b1}}, 3'd7, '0, 3'd1);
            3: begin
               // same code on both cards: clear wins
               code     = rand_uid();
               code_len = LEN_W'($urandom_range(7, 1));
               program_codes(code, code_len, code, code_len);
            end
            4: program_codes(rand_uid(), LEN_W'($urandom_range(7, 1)),
                             rand_uid(), LEN_W'($urandom_range(7, 1)));
            default: ;
         endcase

         if (phase == 0) begin
            // guest with and without material
            send_deposit(deposit(0, '0, 3'd0, MAT_NONE));
            send_deposit(deposit(0, {UID_W{1'b1}}, 3'd7, MAT_PLASTIC));
            // enroll, then find again with other bytes above the length
            send_deposit(deposit(1, 56'hFFEEDD44556677, 3'd4, MAT_GLASS));
            send_deposit(deposit(1, 56'h00000044556677, 3'd4, MAT_METAL));
            // same bytes, longer length is another card
            send_deposit(deposit(1, 56'h00000044556677, 3'd5, MAT_CUP));
            send_deposit(deposit(1, {UID_W{1'b1}}, 3'd7, MAT_CUP));
            // unused material codes count nothing
            send_deposit(deposit(1, '0, 3'd1, MAT_RSVD5));
            send_deposit(deposit(1, '0, 3'd1, MAT_RSVD6));
            send_deposit(deposit(1, '0, 3'd1, MAT_RSVD7));
            // zero length matches any other zero-length card
            send_deposit(deposit(1, 56'h000000ABCDEF, 3'd0, MAT_PLASTIC));
            send_deposit(deposit(1, 56'h00000000000123, 3'd0, MAT_GLASS));
            // master read, then a near miss on length
            send_deposit(deposit(1, MASTER_UID_RST, 3'd7, MAT_GLASS));
            send_deposit(deposit(1, MASTER_UID_RST, 3'd6, MAT_METAL));
            // clear with noise above its length, then near misses
            send_deposit(deposit(1, CLEAR_UID_RST | 56'h5A5A5A00000000, 3'd4, MAT_CUP));
            send_deposit(deposit(1, CLEAR_UID_RST, 3'd5, MAT_PLASTIC));
            send_deposit(deposit(0, CLEAR_UID_RST, 3'd4, MAT_METAL));
            send_deposit(deposit(1, MASTER_UID_RST, 3'd7, MAT_NONE));
            send_deposit(deposit(0, '0, 3'd0, MAT_RSVD7));

            // drive one user and the guest past their counter wrap
            for (int n = 0; n < WRAP_PAIRS; n++) begin
               send_deposit(deposit(1, (rand_uid() & ~ledger.byte_mask(pool_len[0])) |
                                       (pool_uid[0] & ledger.byte_mask(pool_len[0])),
                                    pool_len[0], MAT_PLASTIC));
               send_deposit(deposit(0, rand_uid(), LEN_W'($urandom_range(7)), MAT_CUP));
            end
            repeat (100) send_deposit(random_deposit());
         end else begin
            repeat (120) send_deposit(random_deposit());
         end
         drain_block();
      end

      $display("Covered %0d deposit items and %0d reports, %0d enrollments,",
               ledger.deposits, ledger.reports, ledger.enrolls);
      $display("over %0d code settings; %0d clears, %0d master reads, %0d full-table hits.",
               PHASES, ledger.clears, ledger.masters, ledger.full_hits);
      if (ledger.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/cutt_pkg.sv
src/cutt_cell.sv
src/card_user_table_with_tallies.sv
tb/card_user_table_with_tallies_tb.sv
